[hw/rtl/nsc_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared codes, character constants, lookup tables and the verdict type.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int MAX_LEN  = 255;
  localparam int HEAD_LEN = 6;
  localparam int TAIL_LEN = 5;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_SHORT    = 3'd1;
  localparam logic [2:0] ERR_NO_STAR  = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM = 3'd3;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd4;
  localparam logic [2:0] ERR_TALKER   = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG = 3'd6;

  localparam int NUM_TALKERS = 5;
  localparam int NUM_KINDS   = 14;

  localparam logic [3:0] KIND_NONE = 4'd14;

  localparam logic [0:NUM_TALKERS-1][15:0] TALKERS = {"GP", "GL", "GA", "GB", "GN"};

  localparam logic [0:NUM_KINDS-1][23:0] KINDS = {
    "DTM", "GBS", "GGA", "GLL", "GNS", "GRS", "GSA",
    "GST", "GSV", "RMC", "TXT", "VLW", "VTG", "ZDA"
  };

  typedef struct packed {
    logic [2:0] err;
    logic [2:0] talker;
    logic [3:0] kind;
    logic [7:0] length;
  } verdict_t;

  // bit 4 set marks a valid hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {["0":"9"]}) begin
      r = {1'b1, 4'(c - "0")};
    end else if (c inside {["A":"F"]}) begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end else if (c inside {["a":"f"]}) begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end
    return r;
  endfunction

endpackage

[hw/rtl/nmea_sentence_checker.sv]
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Collects received bytes into sentences and grades each one at its line feed.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  byte     | byte_valid / byte_stall     | rx_byte
//  verdict  | verdict_valid / verdict_stall | error_code, talker_code,
//           |                             | sentence_kind, sentence_length
//
//  One byte a cycle is taken into an input register while byte_stall is low; the
//  registered byte then updates the sentence state and, on a line feed, loads the
//  verdict register. Zero bytes are taken and dropped.
//  A held verdict stalls the input only when a line feed waits behind it.
//  Synchronous reset clears the sentence state and both valid flags.
// ----------------------------------------------------------------------------
module nmea_sentence_checker import nsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] rx_byte,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic [2:0] error_code,
  output logic [2:0] talker_code,
  output logic [3:0] sentence_kind,
  output logic [7:0] sentence_length
);

  logic                     s1_valid;
  logic [7:0]               s1_byte;
  logic [7:0]               byte_count;
  logic [7:0]               running_xor;
  logic [HEAD_LEN-1:0][7:0] head_bytes;
  logic [TAIL_LEN-1:0][7:0] tail_window;
  logic                     overflow_seen;

  logic                     s1_lf;
  logic                     s1_go;
  logic                     byte_take;
  logic [7:0]               byte_count_next;
  logic [7:0]               running_xor_next;
  logic [HEAD_LEN-1:0][7:0] head_bytes_next;
  logic [TAIL_LEN-1:0][7:0] tail_window_next;
  logic                     overflow_seen_next;
  verdict_t                 verdict;

  assign s1_lf      = s1_byte == CH_LF;
  assign s1_go      = s1_valid && (!s1_lf || !verdict_valid || !verdict_stall);
  assign byte_stall = s1_valid && !s1_go;
  assign byte_take  = byte_valid && !byte_stall;

  always_comb begin
    overflow_seen_next = overflow_seen || (byte_count >= 8'(MAX_LEN));
    head_bytes_next    = head_bytes;
    if (byte_count < 8'(HEAD_LEN)) begin
      head_bytes_next[byte_count[2:0]] = s1_byte;
    end
    running_xor_next = (byte_count != 8'd0) ? (running_xor ^ s1_byte) : running_xor;
    tail_window_next = {s1_byte, tail_window[TAIL_LEN-1:1]};
    byte_count_next  = (byte_count != 8'hFF) ? byte_count + 8'd1 : byte_count;
  end

  nsc_verdict u_verdict (
    .overflow (overflow_seen_next),
    .count    (byte_count_next),
    .xor_sum  (running_xor_next),
    .head     (head_bytes_next),
    .tail     (tail_window_next),
    .verdict  (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_take) begin
      s1_valid <= rx_byte != CH_NUL;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 8'd0;
      running_xor   <= 8'd0;
      head_bytes    <= '0;
      tail_window   <= '0;
      overflow_seen <= 1'b0;
    end else if (s1_go) begin
      if (s1_lf) begin
        byte_count    <= 8'd0;
        running_xor   <= 8'd0;
        head_bytes    <= '0;
        tail_window   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        byte_count    <= byte_count_next;
        running_xor   <= running_xor_next;
        head_bytes    <= head_bytes_next;
        tail_window   <= tail_window_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_go && s1_lf) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_lf) begin
      error_code      <= verdict.err;
      talker_code     <= verdict.talker;
      sentence_kind   <= verdict.kind;
      sentence_length <= verdict.length;
    end
  end

  a_clear_after_lf: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_lf |=> byte_count == 8'd0 && running_xor == 8'd0 && !overflow_seen)
    else $error("sentence state not cleared after line feed");

  a_stall_only_on_lf: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> s1_valid && s1_lf && verdict_valid)
    else $error("input stalled without a waiting line feed");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && error_code != ERR_OK |-> talker_code == 3'd0 && sentence_kind == KIND_NONE)
    else $error("talker or kind set on a failed sentence");

  a_ok_length: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && error_code == ERR_OK |-> sentence_length >= 8'(HEAD_LEN))
    else $error("good sentence shorter than its header");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> error_code <= ERR_TOO_LONG)
    else $error("error code out of range");

endmodule

[hw/rtl/nsc_verdict.sv]
// ----------------------------------------------------------------------------
// NMEA sentence verdict
// Grades a finished sentence: length, star, checksum, dollar, talker and type.
// ----------------------------------------------------------------------------
module nsc_verdict import nsc_pkg::*; (
  input  logic                         overflow,
  input  logic [7:0]                   count,
  input  logic [7:0]                   xor_sum,
  input  logic [HEAD_LEN-1:0][7:0]     head,
  input  logic [TAIL_LEN-1:0][7:0]     tail,
  output verdict_t                     verdict
);

  logic [7:0] span_xor;
  logic [4:0] hi_digit;
  logic [4:0] lo_digit;
  logic       talker_hit;
  logic [2:0] talker_idx;
  logic       kind_hit;
  logic [3:0] kind_idx;

  always_comb begin
    span_xor = xor_sum ^ tail[0] ^ tail[1] ^ tail[2] ^ tail[3] ^ tail[4];
    hi_digit = hex_digit(tail[1]);
    lo_digit = hex_digit(tail[2]);

    talker_hit = 1'b0;
    talker_idx = 3'd0;
    for (int i = NUM_TALKERS - 1; i >= 0; i--) begin
      if ({head[1], head[2]} == TALKERS[i]) begin
        talker_hit = 1'b1;
        talker_idx = 3'(i);
      end
    end

    kind_hit = 1'b0;
    kind_idx = KIND_NONE;
    for (int k = NUM_KINDS - 1; k >= 0; k--) begin
      if ({head[3], head[4], head[5]} == KINDS[k]) begin
        kind_hit = 1'b1;
        kind_idx = 4'(k);
      end
    end
  end

  always_comb begin
    verdict.length = count;
    verdict.talker = 3'd0;
    verdict.kind   = KIND_NONE;
    if (overflow) begin
      verdict.err = ERR_TOO_LONG;
    end else if (count < 8'(HEAD_LEN)) begin
      verdict.err = ERR_SHORT;
    end else if (tail[0] != CH_STAR) begin
      verdict.err = ERR_NO_STAR;
    end else if (!hi_digit[4] || !lo_digit[4] || {hi_digit[3:0], lo_digit[3:0]} != span_xor) begin
      verdict.err = ERR_CHECKSUM;
    end else if (head[0] != CH_DOLLAR) begin
      verdict.err = ERR_NO_DOLLAR;
    end else if (!talker_hit) begin
      verdict.err = ERR_TALKER;
    end else begin
      verdict.err    = ERR_OK;
      verdict.talker = talker_idx;
      verdict.kind   = kind_hit ? kind_idx : KIND_NONE;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Feeds sentences byte by byte, some well formed and some broken, and grades
// each line feed in a local copy of the sentence state. Each verdict from the
// block is compared field by field with the oldest graded line.
// ----------------------------------------------------------------------------
module tb_top;
  import nsc_pkg::*;

  typedef enum int {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_e;
  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_NO_STAR, FLAW_NO_DOLLAR, FLAW_NOT_HEX,
                    FLAW_LOWER} flaw_e;

  localparam int CYCLE_LIMIT = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       verdict_valid;
  logic       verdict_stall = 1'b0;
  logic [2:0] error_code;
  logic [2:0] talker_code;
  logic [3:0] sentence_kind;
  logic [7:0] sentence_length;

  logic [7:0] byte_q[$];
  verdict_t   verdict_q[$];
  verdict_t   graded;
  verdict_t   want;
  phase_e     phase = PH_FREE;
  int         calm = 0;
  int         cycles = 0;
  int         bytes_queued = 0;
  int         lines_queued = 0;
  bit         failed = 1'b0;

  logic [7:0] line_len;
  logic [7:0] line_xor;
  logic [7:0] line_head[HEAD_LEN];
  logic [7:0] line_tail[TAIL_LEN];
  bit         line_over;

  nmea_sentence_checker uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void clear_line();
    line_len = 8'd0;
    line_xor = 8'd0;
    line_over = 1'b0;
    foreach (line_head[i]) line_head[i] = 8'd0;
    foreach (line_tail[i]) line_tail[i] = 8'd0;
  endfunction

  // advance the sentence state by one byte; true when a verdict falls due
  function automatic bit grade_byte(input logic [7:0] c, output verdict_t v);
    int hi;
    int lo;
    logic [7:0] sum;
    v.err = ERR_OK;
    v.talker = 3'd0;
    v.kind = KIND_NONE;
    v.length = 8'd0;
    if (c == CH_NUL) return 1'b0;
    if (line_len >= MAX_LEN) line_over = 1'b1;
    if (line_len < HEAD_LEN) line_head[line_len] = c;
    if (line_len >= 1) line_xor ^= c;
    for (int i = 0; i < TAIL_LEN - 1; i++) line_tail[i] = line_tail[i + 1];
    line_tail[TAIL_LEN - 1] = c;
    if (line_len != 8'hFF) line_len++;
    if (c != CH_LF) return 1'b0;
    if (line_over) begin
      v.err = ERR_TOO_LONG;
    end else if (line_len < HEAD_LEN) begin
      v.err = ERR_SHORT;
    end else if (line_tail[0] != CH_STAR) begin
      v.err = ERR_NO_STAR;
    end else begin
      hi = hex_val(line_tail[1]);
      lo = hex_val(line_tail[2]);
      sum = line_xor;
      foreach (line_tail[i]) sum ^= line_tail[i];
      if (hi < 0 || lo < 0 || 8'(hi * 16 + lo) != sum) begin
        v.err = ERR_CHECKSUM;
      end else if (line_head[0] != CH_DOLLAR) begin
        v.err = ERR_NO_DOLLAR;
      end else begin
        v.err = ERR_TALKER;
        for (int i = 0; i < NUM_TALKERS; i++) begin
          if (v.err == ERR_TALKER && line_head[1] == TALKERS[i][15:8] &&
              line_head[2] == TALKERS[i][7:0]) begin
            v.err = ERR_OK;
            v.talker = 3'(i);
          end
        end
        for (int i = 0; i < NUM_KINDS; i++) begin
          if (v.err == ERR_OK && v.kind == KIND_NONE && line_head[3] == KINDS[i][23:16] &&
              line_head[4] == KINDS[i][15:8] && line_head[5] == KINDS[i][7:0]) begin
            v.kind = 4'(i);
          end
        end
      end
    end
    v.length = line_len;
    clear_line();
    return 1'b1;
  endfunction

  function automatic bit idle_now(input bit sender);
    int pct;
    pct = 0;
    if (phase == PH_BOTH) pct = 16;
    else if (sender && phase == PH_SEND_IDLE) pct = 88;
    else if (!sender && phase == PH_RECV_STALL) pct = 88;
    return calm == 0 && $urandom_range(0, 99) < pct;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) byte_q.push_back(CH_NUL);
    byte_q.push_back(b);
    if (b != CH_NUL) bytes_queued++;
    if (b == CH_LF) lines_queued++;
  endfunction

  function automatic logic [7:0] any_byte_but(input logic [7:0] avoid);
    logic [7:0] c;
    c = CH_LF;
    while (c == CH_LF || c == avoid) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 10) return 8'("0" + nib);
    return lower ? 8'("a" + nib - 10) : 8'("A" + nib - 10);
  endfunction

  function automatic void push_sentence(input int talk_sel, input int kind_sel,
                                        input int body_len, input flaw_e flaw);
    logic [7:0] s[$];
    logic [7:0] sum;
    logic [7:0] c;
    bit lower;
    s.push_back(flaw == FLAW_NO_DOLLAR ? any_byte_but(CH_DOLLAR) : CH_DOLLAR);
    if (talk_sel < NUM_TALKERS) begin
      s.push_back(TALKERS[talk_sel][15:8]);
      s.push_back(TALKERS[talk_sel][7:0]);
    end else begin
      repeat (2) s.push_back(8'($urandom_range("A", "Z")));
    end
    if (kind_sel < NUM_KINDS) begin
      s.push_back(KINDS[kind_sel][23:16]);
      s.push_back(KINDS[kind_sel][15:8]);
      s.push_back(KINDS[kind_sel][7:0]);
    end else begin
      repeat (3) s.push_back(8'($urandom_range("A", "Z")));
    end
    s.push_back(",");
    repeat (body_len) begin
      if ($urandom_range(0, 3) == 0) c = any_byte_but(CH_LF);
      else c = 8'($urandom_range(32, 126));
      s.push_back(c);
    end
    sum = 8'd0;
    for (int i = 1; i < s.size(); i++) sum ^= s[i];
    if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));
    s.push_back(flaw == FLAW_NO_STAR ? any_byte_but(CH_STAR) : CH_STAR);
    lower = flaw == FLAW_LOWER || $urandom_range(0, 1) == 1;
    s.push_back(hex_char(sum[7:4], lower));
    s.push_back(hex_char(sum[3:0], lower));
    if (flaw == FLAW_NOT_HEX) begin
      c = any_byte_but(CH_LF);
      while (hex_val(c) >= 0) c = any_byte_but(CH_LF);
      s[s.size() - 1 - $urandom_range(0, 1)] = c;
    end
    s.push_back($urandom_range(0, 7) == 0 ? any_byte_but(CH_LF) : 8'h0D);
    s.push_back(CH_LF);
    foreach (s[i]) push_byte(s[i]);
  endfunction

  task automatic wait_drained();
    while (byte_q.size() != 0 || byte_valid || verdict_q.size() != 0) @(negedge clk);
  endtask

  // driver: grade each accepted byte, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      rx_byte <= 8'd0;
      calm <= 0;
      clear_line();
    end else begin
      if (byte_valid && !byte_stall) begin
        if (grade_byte(rx_byte, graded)) verdict_q.push_back(graded);
      end
      if (calm > 0) calm <= calm - 1;
      else if ($urandom_range(0, 99) < 2) calm <= $urandom_range(20, 60);
      if (!byte_valid || !byte_stall) begin
        if (byte_q.size() > 0 && !idle_now(1'b1)) begin
          byte_valid <= 1'b1;
          rx_byte <= byte_q.pop_front();
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each accepted verdict against the oldest graded line
  always @(posedge clk) begin
    if (rst) begin
      verdict_stall <= 1'b0;
    end else begin
      if (verdict_valid === 1'b1 && !verdict_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, error_code %0d length %0d",
                   $time, error_code, sentence_length);
          failed = 1'b1;
        end else begin
          want = verdict_q.pop_front();
          if (error_code !== want.err) begin
            $display("%0t: error_code expected %0d, got %0d", $time, want.err, error_code);
            failed = 1'b1;
          end
          if (talker_code !== want.talker) begin
            $display("%0t: talker_code expected %0d, got %0d",
                     $time, want.talker, talker_code);
            failed = 1'b1;
          end
          if (sentence_kind !== want.kind) begin
            $display("%0t: sentence_kind expected %0d, got %0d",
                     $time, want.kind, sentence_kind);
            failed = 1'b1;
          end
          if (sentence_length !== want.length) begin
            $display("%0t: sentence_length expected %0d, got %0d",
                     $time, want.length, sentence_length);
            failed = 1'b1;
          end
        end
      end
      verdict_stall <= idle_now(1'b0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int byte_goal;
    int line_goal;
    int n;
    push_byte(CH_LF);
    push_sentence(0, 2, 5, FLAW_NONE);
    push_sentence(1, 9, 3, FLAW_NONE);
    push_sentence(2, 13, 0, FLAW_NONE);
    push_sentence(3, 10, 8, FLAW_NONE);
    push_sentence(4, 12, 4, FLAW_NONE);
    push_sentence(0, NUM_KINDS, 2, FLAW_NONE);
    push_sentence(NUM_TALKERS, 0, 2, FLAW_NONE);
    push_sentence(0, 1, 3, FLAW_LOWER);
    push_sentence(1, 3, 3, FLAW_SUM);
    push_sentence(2, 4, 3, FLAW_NOT_HEX);
    push_sentence(3, 5, 3, FLAW_NO_STAR);
    push_sentence(4, 6, 3, FLAW_NO_DOLLAR);
    push_byte(CH_DOLLAR);
    push_byte("G");
    push_byte("P");
    push_byte(CH_LF);
    push_byte(8'hFF);
    push_byte(CH_LF);
    push_sentence(0, 7, 243, FLAW_NONE);
    push_sentence(0, 8, 244, FLAW_NONE);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    for (int p = PH_FREE; p <= PH_BOTH; p++) begin
      phase = phase_e'(p);
      byte_goal = bytes_queued + 20;
      line_goal = lines_queued + 3;
      while (bytes_queued < byte_goal || lines_queued < line_goal) begin
        n = $urandom_range(0, 99);
        if (n < 70) begin
          push_sentence($urandom_range(0, NUM_TALKERS), $urandom_range(0, NUM_KINDS),
                        $urandom_range(0, 10),
                        $urandom_range(0, 1) ? FLAW_NONE : flaw_e'($urandom_range(1, 5)));
        end else if (n < 85) begin
          repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(0, 7)) push_byte(any_byte_but(CH_LF));
          push_byte(CH_LF);
        end
        while (byte_q.size() > 64) @(negedge clk);
      end
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
